// File: rtl/hrpc_pkg.sv
// ----------------------------------------------------------------------------
// hrpc_pkg
// Types, codes and constant functions shared by the heading rotator blocks.
// ----------------------------------------------------------------------------
package hrpc_pkg;

    typedef enum logic [1:0] {
        MODE_MOUSE_YAW   = 2'd0,
        MODE_JOY_YAW     = 2'd1,
        MODE_JOY_PITCH   = 2'd2,
        MODE_MOUSE_PITCH = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_PITCH,
        S_MUL_X,
        S_MUL_Y,
        S_LAUNCH,
        S_CORDIC,
        S_DONE
    } t_state;

    localparam logic [2:0] CFG_MOUSE_TURN_GAIN  = 3'd0;
    localparam logic [2:0] CFG_JOY_TURN_GAIN    = 3'd1;
    localparam logic [2:0] CFG_MOUSE_PITCH_GAIN = 3'd2;
    localparam logic [2:0] CFG_JOY_PITCH_GAIN   = 3'd3;
    localparam logic [2:0] CFG_PITCH_LIMIT      = 3'd4;
    localparam logic [2:0] CFG_JOY_DEAD_ZONE    = 3'd5;

    localparam int unsigned ATAN_LEN = 30;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

    localparam logic [30:0] ATAN_Q30 [ATAN_LEN] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516,  31'd16775851,  31'd8388437,   31'd4194283,   31'd2097149,
        31'd1048576,   31'd524288,    31'd262144,    31'd131072,    31'd65536,
        31'd32768,     31'd16384,     31'd8192,      31'd4096,      31'd2048,
        31'd1024,      31'd512,       31'd256,       31'd128,       31'd64,
        31'd32,        31'd16,        31'd8,         31'd4,         31'd2
    };

    // Token handed from cell to cell along the rotation chain
    typedef struct packed {
        logic               valid;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
    } t_cordic;

    // Shift-subtract quotient, used at elaboration only
    function automatic logic [63:0] f_udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem    = rem - {1'b0, d};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] f_isqrt64(input logic [63:0] v);
        logic [63:0] val;
        logic [63:0] res;
        logic [63:0] bitv;
        val  = v;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (val >= res + bitv) begin
                val = val - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Rotation gain compensation constant in Q30
    function automatic logic [30:0] f_cordic_gain(input int unsigned steps);
        logic [63:0] p;
        logic [63:0] r;
        p = 64'd1 << 62;
        for (int unsigned i = 0; i < ATAN_LEN; i++) begin
            if (i < steps) begin
                p = p - f_udiv64(p, (64'd1 << (2 * i)) + 64'd1);
            end
        end
        r = (f_isqrt64(p) + 64'd1) >> 1;
        return r[30:0];
    endfunction

endpackage

// File: rtl/heading_rotator_pitch_clamp_top.sv
// ----------------------------------------------------------------------------
// heading_rotator_pitch_clamp_top
// Heading vector rotation (compensated CORDIC chain) and clamped pitch offset.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       sink       i_in_valid / o_in_stall  i_mode, i_amount
//  out      source     o_out_valid / i_out_stall o_heading_x, o_heading_y,
//                                               o_pitch_offset
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One item at a time. A rotating yaw item passes the gain step, the two
//  K-scaling multiplies on a shared multiplier, the launch, the cell chain,
//  the heading update and the output load. Pitch items pass the gain, pitch
//  and output-load steps; yaw items that do not turn skip to the output load.
//  The next item is taken in the cycle after the result is loaded.
//  Reset is synchronous; the heading returns to (1.0, 0) and pitch to zero.
//  A stalled result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module heading_rotator_pitch_clamp_top
    import hrpc_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_amount,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_heading_x,
    output logic signed [31:0] o_heading_y,
    output logic signed [31:0] o_pitch_offset,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam logic [30:0] K_Q30 = f_cordic_gain(CORDIC_STEPS);

    // configuration
    logic [23:0] r_mouse_turn_gain;
    logic [23:0] r_joy_turn_gain;
    logic [23:0] r_mouse_pitch_gain;
    logic [23:0] r_joy_pitch_gain;
    logic [30:0] r_pitch_limit;
    logic [14:0] r_joy_dead_zone;

    // block state
    logic signed [31:0] r_hx;
    logic signed [31:0] r_hy;
    logic signed [31:0] r_pitch;

    t_state r_state;
    t_state n_state;

    t_mode              r_mode;
    logic signed [15:0] r_amt;
    logic [23:0]        r_step;
    logic               r_ccw;
    logic               r_neg;
    logic               r_zero;
    logic signed [33:0] r_x0;
    logic signed [33:0] r_y0;
    logic signed [32:0] r_z0;

    logic               r_out_valid;
    logic signed [31:0] r_out_hx;
    logic signed [31:0] r_out_hy;
    logic signed [31:0] r_out_pitch;

    // control from the state decode
    logic w_accept;
    logic w_out_free;
    logic w_launch;
    logic w_load_out;

    // gain multiply and direction decode
    logic [15:0]        w_mag;
    logic [23:0]        w_gain;
    logic [39:0]        w_gprod;
    logic signed [16:0] w_amt17;
    logic signed [16:0] w_dz;
    logic               w_gain_rot;
    logic               w_gain_ccw;
    logic               w_gain_neg;
    logic               w_gain_zero;

    t_cordic w_chain [CORDIC_STEPS + 1];

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mouse_turn_gain  <= '0;
            r_joy_turn_gain    <= '0;
            r_mouse_pitch_gain <= '0;
            r_joy_pitch_gain   <= '0;
            r_pitch_limit      <= 31'd629146;
            r_joy_dead_zone    <= 15'd3277;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MOUSE_TURN_GAIN:  r_mouse_turn_gain  <= i_cfg_data[23:0];
                CFG_JOY_TURN_GAIN:    r_joy_turn_gain    <= i_cfg_data[23:0];
                CFG_MOUSE_PITCH_GAIN: r_mouse_pitch_gain <= i_cfg_data[23:0];
                CFG_JOY_PITCH_GAIN:   r_joy_pitch_gain   <= i_cfg_data[23:0];
                CFG_PITCH_LIMIT:      r_pitch_limit      <= i_cfg_data[30:0];
                CFG_JOY_DEAD_ZONE:    r_joy_dead_zone    <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ---------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_GAIN;
            S_GAIN: begin
                if (r_mode == MODE_JOY_PITCH || r_mode == MODE_MOUSE_PITCH) begin
                    n_state = S_PITCH;
                end else if (w_gain_rot) begin
                    n_state = S_MUL_X;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PITCH:  n_state = S_DONE;
            S_MUL_X:  n_state = S_MUL_Y;
            S_MUL_Y:  n_state = S_LAUNCH;
            S_LAUNCH: n_state = S_CORDIC;
            S_CORDIC: if (w_chain[CORDIC_STEPS].valid) n_state = S_DONE;
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------- state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_launch   = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE:   o_in_stall = 1'b0;
            S_LAUNCH: w_launch   = 1'b1;
            S_DONE:   w_load_out = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- gain multiply and direction decode
    assign w_mag   = r_amt[15] ? (~r_amt + 16'd1) : r_amt;
    assign w_amt17 = {r_amt[15], r_amt};
    assign w_dz    = $signed({2'b00, r_joy_dead_zone});
    assign w_gprod = {24'd0, w_mag} * {16'd0, w_gain};

    always_comb begin
        w_gain      = r_mouse_turn_gain;
        w_gain_rot  = 1'b0;
        w_gain_ccw  = 1'b0;
        w_gain_neg  = 1'b0;
        w_gain_zero = 1'b0;
        unique case (r_mode)
            MODE_MOUSE_YAW: begin
                w_gain     = r_mouse_turn_gain;
                w_gain_rot = (w_amt17 > 17'sd1) || (w_amt17 < -17'sd1);
                w_gain_ccw = w_amt17 > 17'sd1;
            end
            MODE_JOY_YAW: begin
                w_gain     = r_joy_turn_gain;
                w_gain_rot = (w_amt17 < -w_dz) || (w_amt17 > w_dz);
                w_gain_ccw = w_amt17 < -w_dz;
            end
            MODE_JOY_PITCH: begin
                w_gain     = r_joy_pitch_gain;
                w_gain_neg = r_amt[15];
            end
            MODE_MOUSE_PITCH: begin
                w_gain      = r_mouse_pitch_gain;
                w_gain_neg  = w_amt17 > 17'sd1;
                w_gain_zero = (w_amt17 <= 17'sd1) && (w_amt17 >= -17'sd1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= t_mode'(i_mode);
            r_amt  <= i_amount;
        end
        if (r_state == S_GAIN) begin
            r_step <= w_gprod[39:16];
            r_ccw  <= w_gain_ccw;
            r_neg  <= w_gain_neg;
            r_zero <= w_gain_zero;
        end
    end

    // ---------------- pitch accumulate and clamp
    logic signed [32:0] w_pstep;
    logic signed [32:0] w_psum;
    logic signed [32:0] w_plim;
    logic signed [32:0] w_pnext;

    always_comb begin
        w_pstep = r_zero ? 33'sd0 : $signed({9'd0, r_step});
        if (r_neg) begin
            w_pstep = -w_pstep;
        end
        w_psum = $signed({r_pitch[31], r_pitch}) + w_pstep;
        w_plim = $signed({2'b00, r_pitch_limit});
        priority if (w_psum > w_plim) begin
            w_pnext = w_plim;
        end else if (w_psum < -w_plim) begin
            w_pnext = -w_plim;
        end else begin
            w_pnext = w_psum;
        end
    end

    // ---------------- K scaling on one shared multiplier
    logic signed [31:0] w_mop;
    logic signed [63:0] w_mprod;
    logic signed [63:0] w_mround;
    logic signed [31:0] w_angle;

    assign w_mop    = (r_state == S_MUL_X) ? r_hx : r_hy;
    assign w_mprod  = w_mop * $signed({1'b0, K_Q30});
    assign w_mround = w_mprod + 64'sd536870912;
    assign w_angle  = ({8'd0, r_step} > HALF_PI_Q30) ? $signed(HALF_PI_Q30)
                                                     : $signed({8'd0, r_step});

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL_X) begin
            r_x0 <= w_mround[63:30];
            r_z0 <= r_ccw ? {w_angle[31], w_angle} : -{w_angle[31], w_angle};
        end
        if (r_state == S_MUL_Y) begin
            r_y0 <= w_mround[63:30];
        end
    end

    // ---------------- rotation chain
    assign w_chain[0] = '{valid: w_launch, x: r_x0, y: r_y0, z: r_z0};

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        hrpc_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g + 1])
        );
    end

    function automatic logic signed [31:0] f_sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // ---------------- state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hx    <= $signed(ONE_Q30);
            r_hy    <= '0;
            r_pitch <= '0;
        end else begin
            if (r_state == S_CORDIC && w_chain[CORDIC_STEPS].valid) begin
                r_hx <= f_sat32(w_chain[CORDIC_STEPS].x);
                r_hy <= f_sat32(w_chain[CORDIC_STEPS].y);
            end
            if (r_state == S_PITCH) begin
                r_pitch <= w_pnext[31:0];
            end
        end
    end

    // ---------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_hx    <= r_hx;
            r_out_hy    <= r_hy;
            r_out_pitch <= r_pitch;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_heading_x    = r_out_hx;
    assign o_heading_y    = r_out_hy;
    assign o_pitch_offset = r_out_pitch;

endmodule

// File: rtl/hrpc_cordic_cell.sv
// ----------------------------------------------------------------------------
// hrpc_cordic_cell
// One micro-rotation of the vector chain, registered towards the next cell.
// ----------------------------------------------------------------------------
module hrpc_cordic_cell
    import hrpc_pkg::*;
#(
    parameter int unsigned STEP = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cordic i_cell,
    output t_cordic o_cell
);

    localparam logic signed [32:0] ATAN_STEP = $signed({2'b00, ATAN_Q30[STEP]});

    t_cordic r_cell;
    t_cordic n_cell;

    always_comb begin
        n_cell.valid = i_cell.valid;
        // z sign picks the direction; shifts are arithmetic, i.e. floor
        if (!i_cell.z[32]) begin
            n_cell.x = i_cell.x - (i_cell.y >>> STEP);
            n_cell.y = i_cell.y + (i_cell.x >>> STEP);
            n_cell.z = i_cell.z - ATAN_STEP;
        end else begin
            n_cell.x = i_cell.x + (i_cell.y >>> STEP);
            n_cell.y = i_cell.y - (i_cell.x >>> STEP);
            n_cell.z = i_cell.z + ATAN_STEP;
        end
    end

    // only the valid bit is reset; the data fields just follow
    always_ff @(posedge i_clk) begin
        r_cell.x <= n_cell.x;
        r_cell.y <= n_cell.y;
        r_cell.z <= n_cell.z;
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
    end

    assign o_cell = r_cell;

endmodule

// File: test/hrpc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrpc_checker
// Watches the config, input and output channels of the heading rotator, keeps
// its own copy of heading, pitch and settings, and compares every result.
// ----------------------------------------------------------------------------
module hrpc_checker
    import hrpc_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_amount,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_heading_x,
    input  logic signed [31:0] i_heading_y,
    input  logic signed [31:0] i_pitch_offset,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int     ARC_STEPS   = 30;
    localparam longint RIGHT_ANGLE = 64'sd1686629713;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] pitch;
    } t_view;

    longint arctan_q30 [ARC_STEPS] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516,  16775851,  8388437,   4194283,   2097149,
        1048576,   524288,    262144,    131072,    65536,
        32768,     16384,     8192,      4096,      2048,
        1024,      512,       256,       128,       64,
        32,        16,        8,         4,         2
    };

    longint             k_comp;
    longint             cfg_mouse_yaw;
    longint             cfg_joy_yaw;
    longint             cfg_mouse_pitch;
    longint             cfg_joy_pitch;
    longint             cfg_pitch_bound;
    longint             cfg_dead_band;
    logic signed [31:0] head_x;
    logic signed [31:0] head_y;
    logic signed [31:0] pitch_now;
    t_view              views_due [$];
    int                 fails;

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // Product of the per-stage growth, inverted and taken to Q30
    function automatic longint gain_q30(input int unsigned n);
        longint unsigned p;
        p = 64'd1 << 62;
        for (int i = 0; i < ARC_STEPS && i < n; i++)
            p = p - p / ((64'd1 << (2 * i)) + 64'd1);
        return longint'((root_floor(p) + 64'd1) >> 1);
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic void turn_heading(input longint angle, input bit ccw);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        x = (longint'(head_x) * k_comp + (64'sd1 <<< 29)) >>> 30;
        y = (longint'(head_y) * k_comp + (64'sd1 <<< 29)) >>> 30;
        if (angle > RIGHT_ANGLE)
            angle = RIGHT_ANGLE;
        z = ccw ? angle : -angle;
        for (int i = 0; i < CORDIC_STEPS && i < ARC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - arctan_q30[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + arctan_q30[i];
            end
            x = nx;
            y = ny;
        end
        head_x = clip32(x);
        head_y = clip32(y);
    endfunction

    function automatic void bound_pitch(input longint step);
        longint v;
        v = longint'(pitch_now) + step;
        if (v > cfg_pitch_bound)
            v = cfg_pitch_bound;
        if (v < -cfg_pitch_bound)
            v = -cfg_pitch_bound;
        pitch_now = v[31:0];
    endfunction

    function automatic t_view advance_view(input t_mode m, input logic signed [15:0] amt);
        longint a;
        longint mag;
        longint step;
        t_view  v;
        a   = longint'(amt);
        mag = (a < 0) ? -a : a;
        case (m)
            MODE_MOUSE_YAW: begin
                step = (mag * cfg_mouse_yaw) >>> 16;
                if (a > 1)
                    turn_heading(step, 1'b1);
                else if (a < -1)
                    turn_heading(step, 1'b0);
            end
            MODE_JOY_YAW: begin
                // joystick turns the other way round to the mouse
                step = (mag * cfg_joy_yaw) >>> 16;
                if (a < -cfg_dead_band)
                    turn_heading(step, 1'b1);
                else if (a > cfg_dead_band)
                    turn_heading(step, 1'b0);
            end
            MODE_JOY_PITCH: begin
                step = (mag * cfg_joy_pitch) >>> 16;
                bound_pitch((a < 0) ? -step : step);
            end
            default: begin
                step = (mag * cfg_mouse_pitch) >>> 16;
                if (a > 1)
                    bound_pitch(-step);
                else if (a < -1)
                    bound_pitch(step);
                else
                    bound_pitch(0);
            end
        endcase
        v.x     = head_x;
        v.y     = head_y;
        v.pitch = pitch_now;
        return v;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_view want;
        if (!i_rst_n) begin
            k_comp          = gain_q30(CORDIC_STEPS);
            cfg_mouse_yaw   = 0;
            cfg_joy_yaw     = 0;
            cfg_mouse_pitch = 0;
            cfg_joy_pitch   = 0;
            cfg_pitch_bound = 629146;
            cfg_dead_band   = 3277;
            head_x          = ONE_Q30;
            head_y          = '0;
            pitch_now       = '0;
            views_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (views_due.size() == 0) begin
                    $display("%0t: result with nothing due: x=%0d y=%0d pitch=%0d",
                             $time, i_heading_x, i_heading_y, i_pitch_offset);
                    fails++;
                end else begin
                    want = views_due.pop_front();
                    check_field("heading_x", want.x, i_heading_x);
                    check_field("heading_y", want.y, i_heading_y);
                    check_field("pitch_offset", want.pitch, i_pitch_offset);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MOUSE_TURN_GAIN:  cfg_mouse_yaw   = i_cfg_data[23:0];
                    CFG_JOY_TURN_GAIN:    cfg_joy_yaw     = i_cfg_data[23:0];
                    CFG_MOUSE_PITCH_GAIN: cfg_mouse_pitch = i_cfg_data[23:0];
                    CFG_JOY_PITCH_GAIN:   cfg_joy_pitch   = i_cfg_data[23:0];
                    CFG_PITCH_LIMIT:      cfg_pitch_bound = i_cfg_data[30:0];
                    CFG_JOY_DEAD_ZONE:    cfg_dead_band   = i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                views_due.push_back(advance_view(t_mode'(i_mode), i_amount));
        end
        o_fail_count <= fails;
        o_pending    <= views_due.size();
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives heading_rotator_pitch_clamp_top through directed and random phases
// of settings and input items, with random idling and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import hrpc_pkg::*;

    localparam int unsigned STEPS        = 24;
    localparam int          QUIET_LIMIT  = 3000;
    localparam int          LONG_HOLD    = 300;
    localparam int          PHASE_ITEMS  = 250;
    localparam int          PHASES       = 6;
    localparam int          DRAIN_CYCLES = 40;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [1:0]         mode       = '0;
    logic signed [15:0] amount     = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic signed [31:0] heading_x;
    logic signed [31:0] heading_y;
    logic signed [31:0] pitch_offset;
    logic               cfg_valid  = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index  = '0;
    logic [31:0]        cfg_data   = '0;

    int                 fail_count;
    int                 pending;
    bit                 in_jitter  = 1'b1;
    bit                 out_jitter = 1'b1;
    int                 holds_asked;
    int                 holds_served;
    int                 quiet;
    logic [14:0]        dead_band  = 15'd3277;

    heading_rotator_pitch_clamp_top #(
        .CORDIC_STEPS(STEPS)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_mode        (mode),
        .i_amount      (amount),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_heading_x   (heading_x),
        .o_heading_y   (heading_y),
        .o_pitch_offset(pitch_offset),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    hrpc_checker #(
        .CORDIC_STEPS(STEPS)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_mode        (mode),
        .i_amount      (amount),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_heading_x   (heading_x),
        .i_heading_y   (heading_y),
        .i_pitch_offset(pitch_offset),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #5 clk = ~clk;

    // Watchdog: any transfer on any channel resets the count
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("** heading_rotator_pitch_clamp_top: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Output back-pressure: short random bursts, or one long hold on request
    initial begin
        forever begin
            @(posedge clk);
            if (holds_served != holds_asked) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                holds_served++;
                out_stall <= 1'b0;
            end else if (out_jitter && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [31:0] mouse_yaw, input logic [31:0] joy_yaw,
                                  input logic [31:0] mouse_pitch, input logic [31:0] joy_pitch,
                                  input logic [31:0] bound, input logic [31:0] band);
        write_reg(CFG_MOUSE_TURN_GAIN, mouse_yaw);
        write_reg(CFG_JOY_TURN_GAIN, joy_yaw);
        write_reg(CFG_MOUSE_PITCH_GAIN, mouse_pitch);
        write_reg(CFG_JOY_PITCH_GAIN, joy_pitch);
        write_reg(CFG_PITCH_LIMIT, bound);
        write_reg(CFG_JOY_DEAD_ZONE, band);
        cfg_valid <= 1'b0;
        dead_band = band[14:0];
    endtask

    task automatic send_item(input t_mode m, input logic signed [15:0] a);
        if (in_jitter && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        amount   <= a;
        do @(posedge clk); while (in_stall);
    endtask

    // pending is registered, so look only after the next edge
    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_bound();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 2000);
            1:       return $urandom_range(0, 40000000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_band();
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 64);
        return $urandom();
    endfunction

    function automatic logic signed [15:0] pick_amount();
        int d;
        case ($urandom_range(0, 9))
            0:    return 16'sh7FFF;
            1:    return 16'sh8000;
            2, 3: return 16'(int'($urandom_range(0, 6)) - 3);
            4: begin
                // straddle the dead zone edge
                d = int'(dead_band) + int'($urandom_range(0, 4)) - 2;
                if (d > 32767)
                    d = 32767;
                if (d < 0)
                    d = 0;
                return ($urandom_range(0, 1) != 0) ? 16'(d) : 16'(-d);
            end
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: all gains zero, so nothing moves
        send_item(MODE_MOUSE_YAW, 16'sd100);
        send_item(MODE_MOUSE_PITCH, -16'sd100);
        in_valid <= 1'b0;
        wait_drained();

        apply_settings(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF,
                       32'd10000000, 32'd3277);
        // mouse yaw: extremes and the no-turn band of -1..1
        send_item(MODE_MOUSE_YAW, 16'sd32767);
        send_item(MODE_MOUSE_YAW, -16'sd32768);
        send_item(MODE_MOUSE_YAW, 16'sd2);
        send_item(MODE_MOUSE_YAW, -16'sd2);
        send_item(MODE_MOUSE_YAW, 16'sd1);
        send_item(MODE_MOUSE_YAW, -16'sd1);
        send_item(MODE_MOUSE_YAW, 16'sd0);
        // joystick yaw: either side of the dead zone edge
        send_item(MODE_JOY_YAW, 16'sd3277);
        send_item(MODE_JOY_YAW, 16'sd3278);
        send_item(MODE_JOY_YAW, -16'sd3277);
        send_item(MODE_JOY_YAW, -16'sd3278);
        send_item(MODE_JOY_YAW, -16'sd32768);
        // joystick pitch runs into the upper bound
        send_item(MODE_JOY_PITCH, 16'sd32767);
        send_item(MODE_JOY_PITCH, 16'sd32767);
        send_item(MODE_JOY_PITCH, -16'sd1);
        send_item(MODE_JOY_PITCH, 16'sd0);
        // mouse pitch is inverted, then runs into the upper bound
        send_item(MODE_MOUSE_PITCH, 16'sd2);
        send_item(MODE_MOUSE_PITCH, 16'sd1);
        send_item(MODE_MOUSE_PITCH, -16'sd1);
        send_item(MODE_MOUSE_PITCH, -16'sd2);
        send_item(MODE_MOUSE_PITCH, -16'sd32768);
        in_valid <= 1'b0;
        wait_drained();

        // bound lowered under the offset: yaw keeps it, pitch clamps it
        apply_settings(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF,
                       32'd1000, 32'd3277);
        send_item(MODE_MOUSE_YAW, 16'sd500);
        send_item(MODE_JOY_PITCH, 16'sd0);
        in_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1: apply_settings('1, '1, '1, '1, '1, '1);
                2: apply_settings(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                                  32'd0, 32'd0);
                default: apply_settings(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                                        rand_bound(), rand_band());
            endcase
            in_jitter  = (p != PHASES - 1);
            out_jitter = (p != PHASES - 1);
            if (p == 2)
                holds_asked++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == PHASE_ITEMS / 2) begin
                    in_valid <= 1'b0;
                    wait_drained();
                end
                send_item(t_mode'(2'($urandom_range(0, 3))), pick_amount());
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** heading_rotator_pitch_clamp_top: PASSED **");
        else
            $display("** heading_rotator_pitch_clamp_top: FAILED **");
        $finish;
    end

endmodule
